// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the top level of the list manager.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_IMPLY(label, clk, rstn, ante, cons)
`define ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

// ===== rtl/core/allm_pkg.sv =====
// Shared types and constants of the array-backed linked list manager.
package allm_pkg;

    localparam int DEF_CAPACITY = 16;
    localparam int DATA_W       = 32;

    typedef enum logic [1:0] {
        FN_INS_HEAD = 2'd0,
        FN_INS_TAIL = 2'd1,
        FN_REMOVE   = 2'd2,
        FN_READOUT  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_EMPTY     = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ALLOC,
        S_TAIL_WALK,
        S_RM_WALK,
        S_RM_FREE,
        S_RO_WALK,
        S_RESP
    } state_t;

    // Control group from the sequencer to the node store
    typedef struct packed {
        logic rd_en;
        logic val_wr_en;
        logic link_wr_en;
    } store_ctl_t;

endpackage

// ===== rtl/core/allm_node_store.sv =====
// Node pool storage: value and link memories with registered reads.
module allm_node_store #(
    parameter int   CAPACITY = allm_pkg::DEF_CAPACITY,
    localparam int  LINK_W   = $clog2(CAPACITY + 1),
    localparam int  ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  allm_pkg::store_ctl_t               ctl,
    input  logic [ADDR_W-1:0]                  rd_addr,
    input  logic [ADDR_W-1:0]                  wr_addr,
    input  logic signed [allm_pkg::DATA_W-1:0] wr_value,
    input  logic [LINK_W-1:0]                  wr_link,
    output logic signed [allm_pkg::DATA_W-1:0] rd_value,
    output logic [LINK_W-1:0]                  rd_link
);
    import allm_pkg::*;

    logic signed [DATA_W-1:0] value_mem [CAPACITY];
    logic [LINK_W-1:0]        link_mem  [CAPACITY];

    logic [CAPACITY-1:0]      link_valid_reg;
    logic signed [DATA_W-1:0] rd_value_reg;
    logic [LINK_W-1:0]        rd_link_raw_reg;
    logic                     rd_valid_reg;
    logic [ADDR_W-1:0]        rd_addr_reg;

    always_ff @(posedge aclk) begin
        if (ctl.val_wr_en) begin
            value_mem[wr_addr] <= wr_value;
        end
        if (ctl.rd_en) begin
            rd_value_reg <= value_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.link_wr_en) begin
            link_mem[wr_addr] <= wr_link;
        end
        if (ctl.rd_en) begin
            rd_link_raw_reg <= link_mem[rd_addr];
            rd_valid_reg    <= link_valid_reg[rd_addr];
            rd_addr_reg     <= rd_addr;
        end
    end

    // Mark link entries written since reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            link_valid_reg <= '0;
        end else if (ctl.link_wr_en) begin
            link_valid_reg[wr_addr] <= 1'b1;
        end
    end

    // Unwritten entry i links to i+1; the last one lands on the null code
    assign rd_link  = rd_valid_reg ? rd_link_raw_reg
                                   : LINK_W'(rd_addr_reg) + LINK_W'(1);
    assign rd_value = rd_value_reg;

endmodule

// ===== rtl/core/array_linked_list_manager_top.sv =====
// Top level of the array-backed linked list manager with free-list allocation.
//
// The block keeps a singly linked list of signed 32-bit values in a pool of
// CAPACITY nodes; unused nodes sit on a free list. Reset chains the whole pool
// as the free list and leaves the list empty; no clearing pass is needed, so
// the block takes beats from the first cycle after reset. Operations (s_func):
// insert at head, insert at tail (status full when the pool is exhausted),
// remove the first node holding s_value (status not found when absent), and
// readout, which returns one beat per element from head to tail with m_last on
// the tail, or a single empty-status beat. Every non-readout operation returns
// exactly one beat with m_out_value zero and m_last set. Freed nodes go to the
// front of the free list, and allocation pops that front. One item is worked
// at a time: s_ready is high only while the sequencer is idle. The walk through
// the link memory does one synchronous read per node, where the next read
// address is the link just read. The result register decouples the sink: a
// finished beat may wait on m_ready while the next item is taken; readout holds
// its walk while the result register is still full.
module array_linked_list_manager_top #(
    parameter int   CAPACITY = allm_pkg::DEF_CAPACITY,
    localparam int  LINK_W   = $clog2(CAPACITY + 1),
    localparam int  ADDR_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input channel
    input  logic                               s_valid,
    output logic                               s_ready,
    input  allm_pkg::func_t                    s_func,
    input  logic signed [allm_pkg::DATA_W-1:0] s_value,
    // result channel
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [allm_pkg::DATA_W-1:0] m_out_value,
    output allm_pkg::status_t                  m_status,
    output logic                               m_last
);
    import allm_pkg::*;

    localparam logic [LINK_W-1:0] NIL = LINK_W'(CAPACITY);

    // Sequencer state
    state_t                   state_reg, state_next;
    func_t                    func_reg, func_next;
    logic signed [DATA_W-1:0] value_reg, value_next;
    status_t                  status_reg, status_next;

    // List pointers
    logic [LINK_W-1:0] list_head_reg, list_head_next;
    logic [LINK_W-1:0] free_head_reg, free_head_next;
    logic [LINK_W-1:0] cur_reg, cur_next;
    logic [LINK_W-1:0] prev_reg, prev_next;
    logic [LINK_W-1:0] new_reg, new_next;

    // Result register
    logic                     m_valid_reg, m_valid_next;
    logic signed [DATA_W-1:0] m_value_reg, m_value_next;
    status_t                  m_status_reg, m_status_next;
    logic                     m_last_reg, m_last_next;

    // Node store interface
    store_ctl_t               st_ctl;
    logic [ADDR_W-1:0]        st_rd_addr;
    logic [ADDR_W-1:0]        st_wr_addr;
    logic [LINK_W-1:0]        st_wr_link;
    logic signed [DATA_W-1:0] st_rd_value;
    logic [LINK_W-1:0]        st_rd_link;

    logic accept;
    logic slot_free;
    logic list_has_node;
    logic free_has_node;
    logic link_has_node;
    logic prev_has_node;
    logic value_hit;
    logic walk_state;

    allm_node_store #(
        .CAPACITY (CAPACITY)
    ) u_store (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (st_ctl),
        .rd_addr  (st_rd_addr),
        .wr_addr  (st_wr_addr),
        .wr_value (value_reg),
        .wr_link  (st_wr_link),
        .rd_value (st_rd_value),
        .rd_link  (st_rd_link)
    );

    assign s_ready   = (state_reg == S_IDLE);
    assign accept    = s_valid && s_ready;
    assign slot_free = !m_valid_reg || m_ready;

    // A pointer at or above CAPACITY is the null code
    assign list_has_node = (list_head_reg < NIL);
    assign free_has_node = (free_head_reg < NIL);
    assign link_has_node = (st_rd_link < NIL);
    assign prev_has_node = (prev_reg < NIL);

    // States that sit on a node of the list
    assign walk_state = (state_reg == S_TAIL_WALK) || (state_reg == S_RM_WALK) ||
                        (state_reg == S_RO_WALK) || (state_reg == S_RM_FREE);

    // Shared compare unit: node value against the search key
    assign value_hit = (st_rd_value == value_reg);

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    unique case (s_func)
                        FN_INS_HEAD,
                        FN_INS_TAIL: state_next = free_has_node ? S_ALLOC : S_RESP;
                        FN_REMOVE:   state_next = list_has_node ? S_RM_WALK : S_RESP;
                        FN_READOUT:  state_next = list_has_node ? S_RO_WALK : S_RESP;
                        default:     state_next = S_RESP;
                    endcase
                end
            end
            S_ALLOC: begin
                if (func_reg == FN_INS_TAIL && list_has_node) begin
                    state_next = S_TAIL_WALK;
                end else begin
                    state_next = S_RESP;
                end
            end
            S_TAIL_WALK: begin
                if (!link_has_node) begin
                    state_next = S_RESP;
                end
            end
            S_RM_WALK: begin
                priority if (value_hit) begin
                    state_next = S_RM_FREE;
                end else if (!link_has_node) begin
                    state_next = S_RESP;
                end else begin
                    state_next = S_RM_WALK;
                end
            end
            S_RM_FREE: state_next = S_RESP;
            S_RO_WALK: begin
                if (slot_free && !link_has_node) begin
                    state_next = S_IDLE;
                end
            end
            S_RESP: begin
                if (slot_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Datapath, store control and result register
    always_comb begin
        func_next      = func_reg;
        value_next     = value_reg;
        status_next    = status_reg;
        list_head_next = list_head_reg;
        free_head_next = free_head_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        new_next       = new_reg;

        m_valid_next  = m_valid_reg && !m_ready;
        m_value_next  = m_value_reg;
        m_status_next = m_status_reg;
        m_last_next   = m_last_reg;

        st_ctl     = '0;
        st_rd_addr = cur_reg[ADDR_W-1:0];
        st_wr_addr = cur_reg[ADDR_W-1:0];
        st_wr_link = NIL;

        unique case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    func_next  = s_func;
                    value_next = s_value;
                    unique case (s_func)
                        FN_INS_HEAD,
                        FN_INS_TAIL: begin
                            // fetch the link of the node about to be popped
                            st_ctl.rd_en = free_has_node;
                            st_rd_addr   = free_head_reg[ADDR_W-1:0];
                            status_next  = ST_FULL;
                        end
                        FN_REMOVE: begin
                            st_ctl.rd_en = list_has_node;
                            st_rd_addr   = list_head_reg[ADDR_W-1:0];
                            cur_next     = list_head_reg;
                            prev_next    = NIL;
                            status_next  = ST_NOT_FOUND;
                        end
                        FN_READOUT: begin
                            st_ctl.rd_en = list_has_node;
                            st_rd_addr   = list_head_reg[ADDR_W-1:0];
                            cur_next     = list_head_reg;
                            status_next  = ST_EMPTY;
                        end
                        default: status_next = ST_EMPTY;
                    endcase
                end
            end
            S_ALLOC: begin
                // pop the free head and fill the node
                st_ctl.val_wr_en  = 1'b1;
                st_ctl.link_wr_en = 1'b1;
                st_wr_addr        = free_head_reg[ADDR_W-1:0];
                free_head_next    = st_rd_link;
                new_next          = free_head_reg;
                status_next       = ST_OK;
                if (func_reg == FN_INS_TAIL) begin
                    st_wr_link = NIL;
                    if (list_has_node) begin
                        st_ctl.rd_en = 1'b1;
                        st_rd_addr   = list_head_reg[ADDR_W-1:0];
                        cur_next     = list_head_reg;
                    end else begin
                        list_head_next = free_head_reg;
                    end
                end else begin
                    st_wr_link     = list_head_reg;
                    list_head_next = free_head_reg;
                end
            end
            S_TAIL_WALK: begin
                if (link_has_node) begin
                    st_ctl.rd_en = 1'b1;
                    st_rd_addr   = st_rd_link[ADDR_W-1:0];
                    cur_next     = st_rd_link;
                end else begin
                    // hang the new node off the tail
                    st_ctl.link_wr_en = 1'b1;
                    st_wr_addr        = cur_reg[ADDR_W-1:0];
                    st_wr_link        = new_reg;
                end
            end
            S_RM_WALK: begin
                priority if (value_hit) begin
                    status_next = ST_OK;
                    if (prev_has_node) begin
                        st_ctl.link_wr_en = 1'b1;
                        st_wr_addr        = prev_reg[ADDR_W-1:0];
                        st_wr_link        = st_rd_link;
                    end else begin
                        list_head_next = st_rd_link;
                    end
                end else if (link_has_node) begin
                    st_ctl.rd_en = 1'b1;
                    st_rd_addr   = st_rd_link[ADDR_W-1:0];
                    prev_next    = cur_reg;
                    cur_next     = st_rd_link;
                end else begin
                    // end of list without a match
                    status_next = ST_NOT_FOUND;
                end
            end
            S_RM_FREE: begin
                // push the unlinked node onto the free list
                st_ctl.link_wr_en = 1'b1;
                st_wr_addr        = cur_reg[ADDR_W-1:0];
                st_wr_link        = free_head_reg;
                free_head_next    = cur_reg;
            end
            S_RO_WALK: begin
                // hold the walk while the result register is still full
                if (slot_free) begin
                    m_valid_next  = 1'b1;
                    m_value_next  = st_rd_value;
                    m_status_next = ST_OK;
                    m_last_next   = !link_has_node;
                    if (link_has_node) begin
                        st_ctl.rd_en = 1'b1;
                        st_rd_addr   = st_rd_link[ADDR_W-1:0];
                        cur_next     = st_rd_link;
                    end
                end
            end
            S_RESP: begin
                if (slot_free) begin
                    m_valid_next  = 1'b1;
                    m_value_next  = '0;
                    m_status_next = status_reg;
                    m_last_next   = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            list_head_reg <= NIL;
            free_head_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            list_head_reg <= list_head_next;
            free_head_reg <= free_head_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        func_reg     <= func_next;
        value_reg    <= value_next;
        status_reg   <= status_next;
        cur_reg      <= cur_next;
        prev_reg     <= prev_next;
        new_reg      <= new_next;
        m_value_reg  <= m_value_next;
        m_status_reg <= m_status_next;
        m_last_reg   <= m_last_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_out_value = m_value_reg;
    assign m_status    = m_status_reg;
    assign m_last      = m_last_reg;

`include "assert_macros.svh"

    `ASSERT_NEXT(a_accept_leaves_idle, aclk, aresetn, accept, state_reg != S_IDLE)
    `ASSERT_IMPLY(a_heads_disjoint, aclk, aresetn, free_has_node, free_head_reg != list_head_reg)
    `ASSERT_IMPLY(a_walk_on_node, aclk, aresetn, walk_state, cur_reg < NIL)
    `ASSERT_IMPLY(a_no_self_link, aclk, aresetn, st_ctl.link_wr_en, st_wr_link != LINK_W'(st_wr_addr))
    `ASSERT_IMPLY(a_single_beat_last, aclk, aresetn, m_valid && m_status != ST_OK, m_last)

endmodule

// ===== tb/sv/array_linked_list_manager_top_test.sv =====
// Self-checking testbench for the array-backed linked list manager with free list.
module array_linked_list_manager_top_test;

    import allm_pkg::*;

    localparam int         CAP   = DEF_CAPACITY;
    localparam logic [4:0] NIL   = 5'(CAP);
    localparam int         CALM_TAIL = 25;   // last beats sent with no idling
    localparam int         SETTLE    = 40;   // cycles to watch for stray beats at the end

    // One input beat waiting to be sent; drain makes the sender wait for an empty scoreboard
    typedef struct {
        func_t       op;
        logic [31:0] val;
        bit          drain;
    } list_req_t;

    // One result beat the list should return
    typedef struct {
        logic [31:0] val;
        status_t     st;
        logic        last;
    } list_beat_t;

    logic                       aclk = 1'b0;
    logic                       aresetn = 1'b0;
    logic                       s_valid = 1'b0;
    logic                       s_ready;
    func_t                      s_func = FN_INS_HEAD;
    logic signed [DATA_W-1:0]   s_value = '0;
    logic                       m_valid;
    logic                       m_ready = 1'b0;
    logic signed [DATA_W-1:0]   m_out_value;
    status_t                    m_status;
    logic                       m_last;

    list_req_t   pending_items[$];
    list_beat_t  expected_beats[$];
    logic [31:0] palette[8];
    int          mismatch_count = 0;
    int          send_gap = 0;
    int          sink_gap = 0;
    bit          calm = 1'b0;

    // Shadow copy of the node pool, list head and free-list head
    logic [31:0] pool_val[CAP];
    logic [4:0]  pool_lnk[CAP];
    logic [4:0]  head_idx;
    logic [4:0]  free_idx;

    array_linked_list_manager_top uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_func      (s_func),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_value (m_out_value),
        .m_status    (m_status),
        .m_last      (m_last)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    // ---------------------------------------------------------------------
    // Shadow list: a walk bound of its own, and the same pool and free list as the block
    // ---------------------------------------------------------------------

    function automatic bit on_pool(logic [4:0] idx);
        return idx < CAP;
    endfunction

    // Treat an out-of-range link as the end of the chain
    function automatic logic [4:0] next_of(logic [4:0] idx);
        if (!on_pool(idx))
            return NIL;
        return on_pool(pool_lnk[idx[3:0]]) ? pool_lnk[idx[3:0]] : NIL;
    endfunction

    function automatic void push_beat(logic [31:0] val, status_t st, logic last);
        list_beat_t b;
        b.val  = val;
        b.st   = st;
        b.last = last;
        expected_beats.insert(expected_beats.size(), b);
    endfunction

    // Pop the front of the free list, then link the node at the head or behind the tail
    function automatic status_t list_insert(logic [31:0] v, bit at_tail);
        logic [4:0] n;
        logic [4:0] cur;
        int         steps;
        n = free_idx;
        if (!on_pool(n))
            return ST_FULL;
        free_idx = next_of(n);
        pool_val[n[3:0]] = v;
        pool_lnk[n[3:0]] = NIL;
        if (!at_tail) begin
            pool_lnk[n[3:0]] = on_pool(head_idx) ? head_idx : NIL;
            head_idx = n;
            return ST_OK;
        end
        if (!on_pool(head_idx)) begin
            head_idx = n;
            return ST_OK;
        end
        cur = head_idx;
        steps = 0;
        while (steps < CAP && on_pool(next_of(cur))) begin
            cur = next_of(cur);
            steps++;
        end
        pool_lnk[cur[3:0]] = n;
        return ST_OK;
    endfunction

    // Unlink the first match from the head and push its node onto the free list
    function automatic status_t list_remove(logic [31:0] v);
        logic [4:0] prev;
        logic [4:0] cur;
        int         steps;
        prev = NIL;
        cur = head_idx;
        for (steps = 0; steps < CAP && on_pool(cur); steps++) begin
            if (pool_val[cur[3:0]] == v) begin
                if (on_pool(prev))
                    pool_lnk[prev[3:0]] = next_of(cur);
                else
                    head_idx = next_of(cur);
                pool_lnk[cur[3:0]] = on_pool(free_idx) ? free_idx : NIL;
                free_idx = cur;
                return ST_OK;
            end
            prev = cur;
            cur = next_of(cur);
        end
        return ST_NOT_FOUND;
    endfunction

    // One beat per element from head to tail, or a single empty-status beat
    function automatic void list_readout();
        logic [4:0] cur;
        logic [4:0] nxt;
        int         k;
        if (!on_pool(head_idx)) begin
            push_beat('0, ST_EMPTY, 1'b1);
            return;
        end
        cur = head_idx;
        k = 0;
        while (k < CAP && on_pool(cur)) begin
            nxt = next_of(cur);
            push_beat(pool_val[cur[3:0]], ST_OK, !on_pool(nxt) || (k + 1 >= CAP));
            k++;
            cur = nxt;
        end
    endfunction

    // Advance the shadow list by one accepted beat and queue what it returns
    function automatic void apply_item(list_req_t req);
        case (req.op)
            FN_INS_HEAD: push_beat('0, list_insert(req.val, 1'b0), 1'b1);
            FN_INS_TAIL: push_beat('0, list_insert(req.val, 1'b1), 1'b1);
            FN_REMOVE:   push_beat('0, list_remove(req.val), 1'b1);
            default:     list_readout();
        endcase
    endfunction

    function automatic void add_item(func_t op, logic [31:0] val, bit drain);
        list_req_t r;
        r.op    = op;
        r.val   = val;
        r.drain = drain;
        pending_items.insert(pending_items.size(), r);
    endfunction

    // Mostly values from a small palette so removes hit; sometimes a full-width draw
    function automatic logic [31:0] pick_value();
        if ($urandom_range(0, 3) == 0)
            return $urandom();
        return palette[$urandom_range(0, 7)];
    endfunction

    // ---------------------------------------------------------------------
    // Sender: present the front of the queue, hold it until accepted,
    // insert idle bursts between beats and honor drain points
    // ---------------------------------------------------------------------
    always @(posedge aclk) begin : sender
        bit held;
        held = s_valid;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            calm <= (pending_items.size() < CALM_TAIL);
            if (s_valid && s_ready) begin
                apply_item(pending_items.pop_front());
                held = 1'b0;
            end
            // s_valid gets at most one assignment per edge on every path below
            if (!held) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (pending_items.size() == 0 ||
                             (pending_items[0].drain && expected_beats.size() != 0)) begin
                    s_valid <= 1'b0;
                end else if (!calm && $urandom_range(0, 5) == 0) begin
                    send_gap = $urandom_range(0, 6);
                    s_valid <= 1'b0;
                end else begin
                    s_valid <= 1'b1;
                    s_func  <= pending_items[0].op;
                    s_value <= pending_items[0].val;
                end
            end
        end
    end

    // ---------------------------------------------------------------------
    // Receiver: stall in bursts, check each accepted beat against the
    // oldest expectation, field by field
    // ---------------------------------------------------------------------
    always @(posedge aclk) begin : receiver
        list_beat_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_beats.size() == 0) begin
                    $display("%0t: unexpected beat: expected none, got value %0d status %0d last %0d",
                             $time, m_out_value, m_status, m_last);
                    mismatch_count++;
                end else begin
                    want = expected_beats.pop_front();
                    if (m_out_value !== want.val) begin
                        $display("%0t: out_value mismatch: expected %0d, got %0d",
                                 $time, $signed(want.val), m_out_value);
                        mismatch_count++;
                    end
                    if (m_status !== want.st) begin
                        $display("%0t: status mismatch: expected %0d, got %0d",
                                 $time, want.st, m_status);
                        mismatch_count++;
                    end
                    if (m_last !== want.last) begin
                        $display("%0t: last mismatch: expected %0d, got %0d",
                                 $time, want.last, m_last);
                        mismatch_count++;
                    end
                end
            end
            if (sink_gap > 0) begin
                sink_gap--;
                m_ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                sink_gap = $urandom_range(0, 6);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Stimulus, reset and end of run
    // ---------------------------------------------------------------------
    initial begin : stimulus
        int    k;
        int    roll;
        bit    grow;
        func_t op;

        // Reset state of the shadow list: whole pool chained as free list, list empty
        for (k = 0; k < CAP; k++) begin
            pool_val[k] = '0;
            pool_lnk[k] = 5'(k + 1);
        end
        pool_lnk[CAP-1] = NIL;
        head_idx = NIL;
        free_idx = '0;

        palette[0] = 32'h8000_0000;
        palette[1] = 32'h7FFF_FFFF;
        palette[2] = 32'h0000_0000;
        palette[3] = 32'hFFFF_FFFF;
        for (k = 4; k < 8; k++)
            palette[k] = $urandom();

        // Directed: empty readout, remove on an empty list, field extremes,
        // duplicates, removes at head and middle, fill the pool, inserts
        // into a full pool, a full-length readout, a remove on a full list
        add_item(FN_READOUT, $urandom(), 1'b0);
        add_item(FN_REMOVE, 32'd5, 1'b0);
        add_item(FN_INS_HEAD, 32'h8000_0000, 1'b0);
        add_item(FN_INS_HEAD, 32'h7FFF_FFFF, 1'b0);
        add_item(FN_INS_TAIL, 32'h0000_0000, 1'b0);
        add_item(FN_INS_TAIL, 32'hFFFF_FFFF, 1'b0);
        add_item(FN_INS_TAIL, 32'h7FFF_FFFF, 1'b0);
        add_item(FN_READOUT, $urandom(), 1'b0);
        add_item(FN_REMOVE, 32'h7FFF_FFFF, 1'b0);
        add_item(FN_REMOVE, 32'hFFFF_FFFF, 1'b0);
        add_item(FN_READOUT, $urandom(), 1'b0);
        for (k = 0; k < CAP - 3; k++)
            add_item(k[0] ? FN_INS_TAIL : FN_INS_HEAD, pick_value(), 1'b0);
        add_item(FN_INS_HEAD, $urandom(), 1'b0);
        add_item(FN_INS_TAIL, $urandom(), 1'b0);
        add_item(FN_READOUT, $urandom(), 1'b0);
        add_item(FN_REMOVE, 32'h7FFF_FFFF, 1'b0);

        // Random: alternate growing and shrinking phases so the list swings
        // between empty and full; hold the sender for a drained scoreboard twice
        for (k = 0; k < 122; k++) begin
            grow = ((k / 25) % 2) == 0;
            roll = $urandom_range(0, 99);
            if (roll < 12)
                op = FN_READOUT;
            else if (roll < (grow ? 72 : 27))
                op = roll[0] ? FN_INS_HEAD : FN_INS_TAIL;
            else
                op = FN_REMOVE;
            add_item(op, pick_value(), (k == 0) || (k == 75));
        end

        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Drain: wait for the last beat in, every expectation out, then watch a while
        while (pending_items.size() != 0 || s_valid || expected_beats.size() != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);

        if (mismatch_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Watchdog well beyond the slowest legal run
    initial begin : watchdog
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
